// ===== design/grs_pkg.sv =====
// shared constants, codes and types of the grid route sequencer
package grs_pkg;

  localparam int MAX_STEPS    = 16;
  localparam int SENSOR_COUNT = 8;

  localparam int STEP_IDX_W = $clog2(MAX_STEPS);
  localparam int PTR_W      = 5;
  localparam int CELL_W     = 8;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int TSPEED_W   = 10;
  localparam int SPEED_W    = 11;
  localparam int RLEN_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RLEN_W-1:0]   RST_ROUTE_LENGTH = RLEN_W'(1);
  localparam logic [MS_W-1:0]     RST_LEFT_TURN_MS = MS_W'(360);
  localparam logic [MS_W-1:0]     RST_RIGHT_TURN_MS = MS_W'(360);
  localparam logic [MS_W-1:0]     RST_BACK_TURN_MS = MS_W'(700);
  localparam logic [TSPEED_W-1:0] RST_TURN_SPEED = TSPEED_W'(950);
  localparam logic [MS_W-1:0]     RST_DEBOUNCE_MS = MS_W'(120);

  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  typedef enum logic [1:0] {
    PH_FOLLOW = 2'd0,
    PH_TURN   = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    MOTOR_HOLD = 2'd0,
    MOTOR_SET  = 2'd1,
    MOTOR_STOP = 2'd2
  } motor_cmd_e;

  typedef enum logic [1:0] {
    DIR_STRAIGHT = 2'd0,
    DIR_LEFT     = 2'd1,
    DIR_RIGHT    = 2'd2,
    DIR_BACK     = 2'd3
  } turn_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTE_LENGTH  = 3'd0,
    CFG_LEFT_TURN_MS  = 3'd1,
    CFG_RIGHT_TURN_MS = 3'd2,
    CFG_BACK_TURN_MS  = 3'd3,
    CFG_TURN_SPEED    = 3'd4,
    CFG_DEBOUNCE_MS   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CELL_W-1:0] cells;
    turn_e             turn;
  } step_entry_t;

  typedef struct packed {
    logic                  en;
    logic [STEP_IDX_W-1:0] idx;
    step_entry_t           entry;
  } tbl_wr_t;

endpackage

// ===== design/grs_if.sv =====
// request, result and configuration channel interfaces of the grid route sequencer
interface grs_req_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [grs_pkg::SENSOR_COUNT-1:0]    sensor_bits;
  logic [grs_pkg::TIME_W-1:0]          now_ms;
  logic [grs_pkg::STEP_IDX_W-1:0]      step_index;
  logic [grs_pkg::CELL_W-1:0]          step_cells;
  logic [1:0]                          step_turn;

  modport source (
    output valid, mode, sensor_bits, now_ms, step_index, step_cells, step_turn,
    input  ready
  );
  modport sink (
    input  valid, mode, sensor_bits, now_ms, step_index, step_cells, step_turn,
    output ready
  );
endinterface

interface grs_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         route_state;
  logic [grs_pkg::PTR_W-1:0]          step_now;
  logic [grs_pkg::CELL_W-1:0]         cells_counted;
  logic                               follow_enable;
  logic [1:0]                         motor_cmd;
  logic signed [grs_pkg::SPEED_W-1:0] speed_wheel_one;
  logic signed [grs_pkg::SPEED_W-1:0] speed_wheel_two;
  logic signed [grs_pkg::SPEED_W-1:0] speed_wheel_three;
  logic signed [grs_pkg::SPEED_W-1:0] speed_wheel_four;

  modport source (
    output valid, route_state, step_now, cells_counted, follow_enable, motor_cmd,
           speed_wheel_one, speed_wheel_two, speed_wheel_three, speed_wheel_four,
    input  ready
  );
  modport sink (
    input  valid, route_state, step_now, cells_counted, follow_enable, motor_cmd,
           speed_wheel_one, speed_wheel_two, speed_wheel_three, speed_wheel_four,
    output ready
  );
endinterface

interface grs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [grs_pkg::CFG_IDX_W-1:0]  index;
  logic [grs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/grs_route_table.sv =====
// route step table: one write port, one read port
module grs_route_table (
  input  logic                                clk_i,
  input  grs_pkg::tbl_wr_t                    wr_i,
  input  logic [grs_pkg::STEP_IDX_W-1:0]      rd_idx_i,
  output grs_pkg::step_entry_t                rd_o
);

  grs_pkg::step_entry_t mem_q [grs_pkg::MAX_STEPS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.entry;
    end
  end

  assign rd_o = mem_q[rd_idx_i];

endmodule

// ===== design/grid_route_sequencer.sv =====
// grid route sequencer top level
//
// usage: load requests (mode 0) write one route step (cells, turn) into the
// step table; sample requests (mode 1) carry line sensor bits and a ms
// timestamp and advance the route: cell counting with debounce, timed turns
// with four wheel speeds, and a final stop when the last step is done.
// every request, load or sample, gives exactly one result.
// channels: req_i (sink) for requests, res_o (source) for results, cfg_i for
// register writes, which are always taken (ready held high) and must only be
// issued while no request is in flight.
// pipeline: a request is held in the input register, and its result is then
// loaded into the result register; one request per cycle is sustained while
// res_o is taken, set by the single compare-and-update stage.
// reset: registers return to their default values, route starts at step 0 in
// the follow state; the step table keeps no reset value and must be loaded
// before its entries are used.
// stall: while res_o is not taken the result holds, one more request may be
// taken into the input register, then req_i.ready drops.
module grid_route_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  grs_req_if.sink   req_i,
  grs_res_if.source res_o,
  grs_cfg_if.sink   cfg_i
);

  localparam int TW = grs_pkg::TIME_W;
  localparam int PW = grs_pkg::PTR_W;
  localparam int CW = grs_pkg::CELL_W;
  localparam int SW = grs_pkg::SPEED_W;

  // configuration registers
  logic [grs_pkg::RLEN_W-1:0]   route_length_q;
  logic [grs_pkg::MS_W-1:0]     left_turn_ms_q;
  logic [grs_pkg::MS_W-1:0]     right_turn_ms_q;
  logic [grs_pkg::MS_W-1:0]     back_turn_ms_q;
  logic [grs_pkg::TSPEED_W-1:0] turn_speed_q;
  logic [grs_pkg::MS_W-1:0]     debounce_ms_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_length_q  <= grs_pkg::RST_ROUTE_LENGTH;
      left_turn_ms_q  <= grs_pkg::RST_LEFT_TURN_MS;
      right_turn_ms_q <= grs_pkg::RST_RIGHT_TURN_MS;
      back_turn_ms_q  <= grs_pkg::RST_BACK_TURN_MS;
      turn_speed_q    <= grs_pkg::RST_TURN_SPEED;
      debounce_ms_q   <= grs_pkg::RST_DEBOUNCE_MS;
    end else if (cfg_i.valid) begin
      case (grs_pkg::cfg_reg_e'(cfg_i.index))
        grs_pkg::CFG_ROUTE_LENGTH:  route_length_q  <= cfg_i.data[grs_pkg::RLEN_W-1:0];
        grs_pkg::CFG_LEFT_TURN_MS:  left_turn_ms_q  <= cfg_i.data[grs_pkg::MS_W-1:0];
        grs_pkg::CFG_RIGHT_TURN_MS: right_turn_ms_q <= cfg_i.data[grs_pkg::MS_W-1:0];
        grs_pkg::CFG_BACK_TURN_MS:  back_turn_ms_q  <= cfg_i.data[grs_pkg::MS_W-1:0];
        grs_pkg::CFG_TURN_SPEED:    turn_speed_q    <= cfg_i.data[grs_pkg::TSPEED_W-1:0];
        grs_pkg::CFG_DEBOUNCE_MS:   debounce_ms_q   <= cfg_i.data[grs_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                              in_vld_q;
  logic                              mode_q;
  logic [grs_pkg::SENSOR_COUNT-1:0]  sensor_q;
  logic [TW-1:0]                     now_q;
  logic [grs_pkg::STEP_IDX_W-1:0]    sidx_q;
  logic [CW-1:0]                     scells_q;
  logic [1:0]                        sturn_q;

  logic out_vld_q;
  logic adv;
  logic fire;

  assign adv         = !out_vld_q || res_o.ready;
  assign fire        = in_vld_q && adv;
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q   <= req_i.mode;
      sensor_q <= req_i.sensor_bits;
      now_q    <= req_i.now_ms;
      sidx_q   <= req_i.step_index;
      scells_q <= req_i.step_cells;
      sturn_q  <= req_i.step_turn;
    end
  end

  // route state
  grs_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            prev_blk_q, prev_blk_d;
  logic [TW-1:0]   last_q, last_d;
  logic [TW-1:0]   deadline_q, deadline_d;

  grs_pkg::tbl_wr_t     tbl_wr;
  grs_pkg::step_entry_t tbl_rd;

  grs_route_table u_table (
    .clk_i    (clk_i),
    .wr_i     (tbl_wr),
    .rd_idx_i (ptr_q[grs_pkg::STEP_IDX_W-1:0]),
    .rd_o     (tbl_rd)
  );

  grs_pkg::motor_cmd_e cmd;
  logic                follow;
  logic signed [SW-1:0] sp1, sp2, sp3, sp4;

  logic                  in_table;
  logic [CW-1:0]         need;
  grs_pkg::turn_e        turn;
  logic                  blk;
  logic [TW-1:0]         since;
  logic [TW-1:0]         turn_diff;
  logic [CW-1:0]         cnt_inc;
  logic [PW-1:0]         ptr_inc;
  logic [PW-1:0]         len;
  logic signed [SW-1:0]  spd_pos;
  logic signed [SW-1:0]  spd_neg;
  logic [grs_pkg::MS_W-1:0] turn_ms;

  always_comb begin
    in_table  = ptr_q < PW'(grs_pkg::MAX_STEPS);
    need      = in_table ? tbl_rd.cells : '0;
    turn      = in_table ? tbl_rd.turn : grs_pkg::DIR_STRAIGHT;
    blk       = &sensor_q;
    since     = now_q - last_q;
    turn_diff = now_q - deadline_q;
    cnt_inc   = (cnt_q == grs_pkg::CELL_MAX) ? cnt_q : cnt_q + CW'(1);
    ptr_inc   = ptr_q + PW'(1);
    len       = (route_length_q > PW'(grs_pkg::MAX_STEPS)) ? PW'(grs_pkg::MAX_STEPS)
                                                           : PW'(route_length_q);
    spd_pos   = SW'($signed({1'b0, turn_speed_q}));
    spd_neg   = -spd_pos;
    case (turn)
      grs_pkg::DIR_LEFT:  turn_ms = left_turn_ms_q;
      grs_pkg::DIR_RIGHT: turn_ms = right_turn_ms_q;
      default:            turn_ms = back_turn_ms_q;
    endcase

    phase_d    = phase_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    prev_blk_d = prev_blk_q;
    last_d     = last_q;
    deadline_d = deadline_q;
    cmd        = grs_pkg::MOTOR_HOLD;
    follow     = 1'b0;
    sp1        = '0;
    sp2        = '0;
    sp3        = '0;
    sp4        = '0;
    tbl_wr.en          = fire && !mode_q;
    tbl_wr.idx         = sidx_q;
    tbl_wr.entry.cells = scells_q;
    tbl_wr.entry.turn  = grs_pkg::turn_e'(sturn_q);

    if (mode_q) begin
      case (phase_q)
        grs_pkg::PH_TURN: begin
          if (!turn_diff[TW-1]) begin
            phase_d = grs_pkg::PH_FOLLOW;
            cmd     = grs_pkg::MOTOR_STOP;
          end
        end
        grs_pkg::PH_FOLLOW: begin
          follow     = 1'b1;
          prev_blk_d = blk;
          if (blk && !prev_blk_q && (since > TW'(debounce_ms_q))) begin
            last_d = now_q;
            cnt_d  = cnt_inc;
            if (cnt_inc >= need) begin
              cnt_d = '0;
              ptr_d = ptr_inc;
              if (ptr_inc >= len) begin
                phase_d    = grs_pkg::PH_DONE;
                cmd        = grs_pkg::MOTOR_STOP;
                prev_blk_d = prev_blk_q;
              end else if (turn != grs_pkg::DIR_STRAIGHT) begin
                phase_d    = grs_pkg::PH_TURN;
                cmd        = grs_pkg::MOTOR_SET;
                deadline_d = now_q + TW'(turn_ms);
                if (turn == grs_pkg::DIR_LEFT) begin
                  sp1 = spd_neg;
                  sp2 = spd_pos;
                  sp3 = spd_neg;
                  sp4 = spd_pos;
                end else begin
                  sp1 = spd_pos;
                  sp2 = spd_neg;
                  sp3 = spd_pos;
                  sp4 = spd_neg;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= grs_pkg::PH_FOLLOW;
      ptr_q      <= '0;
      cnt_q      <= '0;
      prev_blk_q <= 1'b0;
      last_q     <= '0;
      deadline_q <= '0;
    end else if (fire) begin
      phase_q    <= phase_d;
      ptr_q      <= ptr_d;
      cnt_q      <= cnt_d;
      prev_blk_q <= prev_blk_d;
      last_q     <= last_d;
      deadline_q <= deadline_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  logic [1:0]           res_state_q;
  logic [PW-1:0]        res_step_q;
  logic [CW-1:0]        res_cells_q;
  logic                 res_follow_q;
  logic [1:0]           res_cmd_q;
  logic signed [SW-1:0] res_sp1_q, res_sp2_q, res_sp3_q, res_sp4_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_state_q  <= phase_d;
      res_step_q   <= ptr_d;
      res_cells_q  <= cnt_d;
      res_follow_q <= follow;
      res_cmd_q    <= cmd;
      res_sp1_q    <= sp1;
      res_sp2_q    <= sp2;
      res_sp3_q    <= sp3;
      res_sp4_q    <= sp4;
    end
  end

  assign res_o.valid             = out_vld_q;
  assign res_o.route_state       = res_state_q;
  assign res_o.step_now          = res_step_q;
  assign res_o.cells_counted     = res_cells_q;
  assign res_o.follow_enable     = res_follow_q;
  assign res_o.motor_cmd         = res_cmd_q;
  assign res_o.speed_wheel_one   = res_sp1_q;
  assign res_o.speed_wheel_two   = res_sp2_q;
  assign res_o.speed_wheel_three = res_sp3_q;
  assign res_o.speed_wheel_four  = res_sp4_q;

endmodule

// ===== dv/grs_route_checker.sv =====
// route checker: mirrors the grid route sequencer from watched requests and checks every result
`timescale 1ns / 100ps

module grs_route_checker (
  input  logic clk_i,
  input  logic rst_ni,
  grs_req_if   req_i,
  grs_res_if   res_i,
  grs_cfg_if   cfg_i,
  output int   mismatches_o,
  output int   pending_o
);

  localparam int TW = grs_pkg::TIME_W;
  localparam int PW = grs_pkg::PTR_W;
  localparam int CW = grs_pkg::CELL_W;
  localparam int SW = grs_pkg::SPEED_W;
  localparam int IW = grs_pkg::STEP_IDX_W;
  localparam int RW = grs_pkg::RLEN_W;
  localparam int MW = grs_pkg::MS_W;
  localparam int NS = grs_pkg::MAX_STEPS;
  localparam int SC = grs_pkg::SENSOR_COUNT;

  typedef struct packed {
    grs_pkg::phase_e     state;
    logic [PW-1:0]       step;
    logic [CW-1:0]       cells;
    logic                follow;
    grs_pkg::motor_cmd_e cmd;
    logic signed [SW-1:0] wheel_one;
    logic signed [SW-1:0] wheel_two;
    logic signed [SW-1:0] wheel_three;
    logic signed [SW-1:0] wheel_four;
  } route_report_t;

  logic [RW-1:0]                route_len;
  logic [MW-1:0]                left_ms;
  logic [MW-1:0]                right_ms;
  logic [MW-1:0]                back_ms;
  logic [grs_pkg::TSPEED_W-1:0] spin_mag;
  logic [MW-1:0]                debounce;

  grs_pkg::phase_e     phase;
  logic [PW-1:0]       step_ptr;
  logic [CW-1:0]       cell_cnt;
  logic                prev_black;
  logic [TW-1:0]       last_cross;
  logic [TW-1:0]       turn_deadline;
  logic [CW-1:0]       tbl_cells [NS];
  grs_pkg::turn_e      tbl_turn  [NS];

  route_report_t       pending_reports [$];
  route_report_t       want;

  function automatic route_report_t advance_route(
    input logic          mode,
    input logic [SC-1:0] bits,
    input logic [TW-1:0] now,
    input logic [IW-1:0] idx,
    input logic [CW-1:0] cells,
    input logic [1:0]    turn
  );
    route_report_t        r;
    logic                 black;
    logic                 finished;
    logic [CW-1:0]        need;
    grs_pkg::turn_e       dir;
    logic [RW-1:0]        len;
    logic [TW-1:0]        lag;
    logic signed [SW-1:0] pos;
    logic signed [SW-1:0] neg;
    r = '0;
    if (!mode) begin
      tbl_cells[idx] = cells;
      tbl_turn[idx]  = grs_pkg::turn_e'(turn);
    end else if (phase == grs_pkg::PH_TURN) begin
      lag = now - turn_deadline;
      if (!lag[TW-1]) begin
        phase = grs_pkg::PH_FOLLOW;
        r.cmd = grs_pkg::MOTOR_STOP;
      end
    end else if (phase == grs_pkg::PH_FOLLOW) begin
      black    = &bits;
      finished = 1'b0;
      r.follow = 1'b1;
      lag      = now - last_cross;
      if (black && !prev_black && lag > TW'(debounce)) begin
        last_cross = now;
        if (cell_cnt != grs_pkg::CELL_MAX) cell_cnt = cell_cnt + CW'(1);
        need = '0;
        dir  = grs_pkg::DIR_STRAIGHT;
        if (step_ptr < PW'(NS)) begin
          need = tbl_cells[step_ptr[IW-1:0]];
          dir  = tbl_turn[step_ptr[IW-1:0]];
        end
        if (cell_cnt >= need) begin
          len      = (route_len > RW'(NS)) ? RW'(NS) : route_len;
          cell_cnt = '0;
          step_ptr = step_ptr + PW'(1);
          if (step_ptr >= len) begin
            phase    = grs_pkg::PH_DONE;
            r.cmd    = grs_pkg::MOTOR_STOP;
            finished = 1'b1;
          end else if (dir != grs_pkg::DIR_STRAIGHT) begin
            pos = $signed({1'b0, spin_mag});
            neg = -pos;
            if (dir == grs_pkg::DIR_LEFT) begin
              r.wheel_one   = neg;
              r.wheel_two   = pos;
              r.wheel_three = neg;
              r.wheel_four  = pos;
              turn_deadline = now + TW'(left_ms);
            end else begin
              r.wheel_one   = pos;
              r.wheel_two   = neg;
              r.wheel_three = pos;
              r.wheel_four  = neg;
              turn_deadline = now + TW'((dir == grs_pkg::DIR_RIGHT) ? right_ms : back_ms);
            end
            phase = grs_pkg::PH_TURN;
            r.cmd = grs_pkg::MOTOR_SET;
          end
        end
      end
      if (!finished) prev_black = black;
    end
    r.state = phase;
    r.step  = step_ptr;
    r.cells = cell_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_len     = grs_pkg::RST_ROUTE_LENGTH;
      left_ms       = grs_pkg::RST_LEFT_TURN_MS;
      right_ms      = grs_pkg::RST_RIGHT_TURN_MS;
      back_ms       = grs_pkg::RST_BACK_TURN_MS;
      spin_mag      = grs_pkg::RST_TURN_SPEED;
      debounce      = grs_pkg::RST_DEBOUNCE_MS;
      phase         = grs_pkg::PH_FOLLOW;
      step_ptr      = '0;
      cell_cnt      = '0;
      prev_black    = 1'b0;
      last_cross    = '0;
      turn_deadline = '0;
      for (int i = 0; i < NS; i++) begin
        tbl_cells[i] = '0;
        tbl_turn[i]  = grs_pkg::DIR_STRAIGHT;
      end
      pending_reports.delete();
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (pending_reports.size() == 0) begin
          $error("result with no request outstanding");
          mismatches_o++;
        end else begin
          want = pending_reports.pop_front();
          check_field("route_state", want.state, res_i.route_state);
          check_field("step_now", want.step, res_i.step_now);
          check_field("cells_counted", want.cells, res_i.cells_counted);
          check_field("follow_enable", want.follow, res_i.follow_enable);
          check_field("motor_cmd", want.cmd, res_i.motor_cmd);
          check_field("speed_wheel_one", want.wheel_one, res_i.speed_wheel_one);
          check_field("speed_wheel_two", want.wheel_two, res_i.speed_wheel_two);
          check_field("speed_wheel_three", want.wheel_three, res_i.speed_wheel_three);
          check_field("speed_wheel_four", want.wheel_four, res_i.speed_wheel_four);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          grs_pkg::CFG_ROUTE_LENGTH:  route_len = cfg_i.data[RW-1:0];
          grs_pkg::CFG_LEFT_TURN_MS:  left_ms   = cfg_i.data[MW-1:0];
          grs_pkg::CFG_RIGHT_TURN_MS: right_ms  = cfg_i.data[MW-1:0];
          grs_pkg::CFG_BACK_TURN_MS:  back_ms   = cfg_i.data[MW-1:0];
          grs_pkg::CFG_TURN_SPEED:    spin_mag  = cfg_i.data[grs_pkg::TSPEED_W-1:0];
          grs_pkg::CFG_DEBOUNCE_MS:   debounce  = cfg_i.data[MW-1:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        pending_reports.push_back(advance_route(req_i.mode, req_i.sensor_bits,
                                                req_i.now_ms, req_i.step_index,
                                                req_i.step_cells, req_i.step_turn));
      end
      pending_o <= pending_reports.size();
    end
  end

endmodule

// ===== dv/grid_route_sequencer_test.sv =====
// test top of the grid route sequencer: clock, reset, request and register stimulus, verdict
`timescale 1ns / 100ps

module grid_route_sequencer_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int IDLE_PCT    = 23;

  localparam int TW  = grs_pkg::TIME_W;
  localparam int CW  = grs_pkg::CELL_W;
  localparam int IW  = grs_pkg::STEP_IDX_W;
  localparam int SC  = grs_pkg::SENSOR_COUNT;
  localparam int CIW = grs_pkg::CFG_IDX_W;
  localparam int CDW = grs_pkg::CFG_DATA_W;
  localparam int NS  = grs_pkg::MAX_STEPS;

  localparam logic [CIW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CIW-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [SC-1:0]  SENSE_DARK   = '1;

  logic          clk_i;
  logic          rst_ni;
  logic          steady;
  logic [TW-1:0] clock_ms;
  int            mismatches;
  int            pending;
  int            cycle_cnt = 0;

  grs_req_if req ();
  grs_res_if res ();
  grs_cfg_if cfg ();

  grid_route_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  grs_route_checker u_route_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .res_i        (res),
    .cfg_i        (cfg),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic push_req(input logic mode, input logic [SC-1:0] bits,
                          input logic [TW-1:0] now, input logic [IW-1:0] idx,
                          input logic [CW-1:0] cells, input logic [1:0] turn);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.mode        <= mode;
    req.sensor_bits <= bits;
    req.now_ms      <= now;
    req.step_index  <= idx;
    req.step_cells  <= cells;
    req.step_turn   <= turn;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic send_load(input logic [IW-1:0] idx, input logic [CW-1:0] cells,
                           input logic [1:0] turn);
    push_req(1'b0, SC'($urandom_range(0, 255)), $urandom(), idx, cells, turn);
  endtask

  task automatic send_sample(input logic [SC-1:0] bits, input logic [TW-1:0] now);
    push_req(1'b1, bits, now, IW'($urandom_range(0, 15)), CW'($urandom_range(0, 255)),
             2'($urandom_range(0, 3)));
  endtask

  task automatic write_reg(input logic [CIW-1:0] idx, input logic [CDW-1:0] data);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [TW-1:0] ms_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) return $urandom();
    if (pick < 7) return $urandom_range(0, 200000);
    return $urandom_range(1, 90);
  endfunction

  // mostly black/white crossing pairs on a running clock, plus table loads and noise
  task automatic run_random(input int n);
    int            sent;
    int            pick;
    int            shape;
    logic [CW-1:0] cells;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        shape = $urandom_range(0, 15);
        if (shape == 0) cells = '0;
        else if (shape == 1) cells = CW'($urandom_range(0, 255));
        else cells = CW'($urandom_range(4, 20));
        send_load(IW'($urandom_range(0, 15)), cells, 2'($urandom_range(0, 3)));
        sent++;
      end else if (pick < 18) begin
        send_sample(SC'($urandom_range(0, 255)), $urandom());
        sent++;
      end else begin
        clock_ms = clock_ms + ms_step();
        send_sample(SENSE_DARK, clock_ms);
        clock_ms = clock_ms + ms_step();
        send_sample(SC'($urandom_range(0, 254)), clock_ms);
        sent += 2;
      end
    end
  endtask

  initial begin
    steady          = 1'b0;
    rst_ni          = 1'b0;
    clock_ms        = '0;
    req.valid       = 1'b0;
    req.mode        = 1'b0;
    req.sensor_bits = '0;
    req.now_ms      = '0;
    req.step_index  = '0;
    req.step_cells  = '0;
    req.step_turn   = '0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the whole step table before any step can be read
    for (int i = 1; i < NS; i++) begin
      send_load(IW'(i), (i == NS - 1) ? CW'(0) : CW'(2 + i % 5), 2'(i));
    end
    send_load(IW'(0), grs_pkg::CELL_MAX, grs_pkg::DIR_BACK);

    // debounce edges and timestamp wrap under reset settings
    send_sample(8'h00, 32'd0);
    send_sample(SENSE_DARK, 32'd50);
    send_sample(8'h7f, 32'd310);
    send_sample(SENSE_DARK, 32'd320);
    send_sample(8'hfe, 32'd330);
    send_sample(SENSE_DARK, 32'd440);
    send_sample(8'h00, 32'd450);
    send_sample(SENSE_DARK, 32'd441);
    send_sample(8'h01, 32'd460);
    send_sample(SENSE_DARK, 32'hffff_fff0);
    send_sample(8'h00, 32'h0000_0010);
    send_sample(SENSE_DARK, 32'h0000_0070);
    send_load(IW'(0), 8'd8, grs_pkg::DIR_LEFT);
    wait_drained();

    clock_ms = 32'd1000;
    write_reg(grs_pkg::CFG_ROUTE_LENGTH, {11'($urandom()), 5'd16});
    write_reg(grs_pkg::CFG_LEFT_TURN_MS, 16'd300);
    write_reg(grs_pkg::CFG_RIGHT_TURN_MS, 16'd420);
    write_reg(grs_pkg::CFG_BACK_TURN_MS, 16'd700);
    write_reg(grs_pkg::CFG_TURN_SPEED, 16'd950);
    write_reg(grs_pkg::CFG_DEBOUNCE_MS, 16'd120);
    write_reg(CFG_SPARE_LO, 16'($urandom()));
    write_reg(CFG_SPARE_HI, 16'($urandom()));
    run_random(150);
    wait_drained();

    // no idling on either side in this stretch
    steady = 1'b1;
    write_reg(grs_pkg::CFG_ROUTE_LENGTH, 16'hffff);
    write_reg(grs_pkg::CFG_LEFT_TURN_MS, 16'd0);
    write_reg(grs_pkg::CFG_RIGHT_TURN_MS, 16'hffff);
    write_reg(grs_pkg::CFG_BACK_TURN_MS, 16'd1);
    write_reg(grs_pkg::CFG_TURN_SPEED, 16'hffff);
    write_reg(grs_pkg::CFG_DEBOUNCE_MS, 16'd0);
    run_random(150);
    wait_drained();
    steady = 1'b0;

    write_reg(grs_pkg::CFG_ROUTE_LENGTH, {11'($urandom()), 5'd16});
    write_reg(grs_pkg::CFG_LEFT_TURN_MS, 16'hffff);
    write_reg(grs_pkg::CFG_RIGHT_TURN_MS, 16'd0);
    write_reg(grs_pkg::CFG_BACK_TURN_MS, 16'hffff);
    write_reg(grs_pkg::CFG_TURN_SPEED, 16'd0);
    write_reg(grs_pkg::CFG_DEBOUNCE_MS, 16'hffff);
    run_random(150);
    wait_drained();

    write_reg(grs_pkg::CFG_ROUTE_LENGTH, 16'd20);
    write_reg(grs_pkg::CFG_LEFT_TURN_MS, 16'($urandom_range(0, 1000)));
    write_reg(grs_pkg::CFG_RIGHT_TURN_MS, 16'($urandom()));
    write_reg(grs_pkg::CFG_BACK_TURN_MS, 16'($urandom_range(0, 2000)));
    write_reg(grs_pkg::CFG_TURN_SPEED, 16'($urandom()));
    write_reg(grs_pkg::CFG_DEBOUNCE_MS, 16'($urandom_range(0, 400)));
    run_random(250);
    wait_drained();

    // zero route length: the next completed step ends the route
    write_reg(grs_pkg::CFG_ROUTE_LENGTH, 16'd0);
    write_reg(grs_pkg::CFG_TURN_SPEED, 16'd512);
    write_reg(grs_pkg::CFG_DEBOUNCE_MS, 16'd60);
    run_random(150);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/grs_pkg.sv
design/grs_if.sv
design/grs_route_table.sv
design/grid_route_sequencer.sv
dv/grs_route_checker.sv
dv/grid_route_sequencer_test.sv
